// ===== hw/rtl/cpc_pkg.sv =====
// shared types, constants and helper functions of the circle pair collision resolver
package cpc_pkg;

  localparam int PosW    = 20;
  localparam int VelW    = 15;
  localparam int DiamW   = 16;
  localparam int SpeedW  = 14;
  localparam int DiffW   = PosW + 1;
  localparam int SqW     = 2 * DiffW;
  localparam int VsqW    = 2 * VelW;
  localparam int RatMW   = 16;
  localparam int RatAW   = DiffW;
  localparam int KW      = 18;
  localparam int OffW    = KW + 1;
  localparam int WW      = 17;
  localparam int WMagW   = WW - 1;
  localparam int SwW     = 2 * WMagW;
  localparam int DataW   = 144;
  localparam int CfgW    = 16;

  localparam int FracBits = 8;
  localparam int UnitBits = 14;
  // largest squared distance that still counts as coincident centers
  localparam logic [SqW-1:0] SkipMax = SqW'(((64'd1 << (2 * FracBits)) - 64'd1) / 64'd100);
  localparam logic [RatMW-1:0] UnitM = RatMW'(64'd1 << (UnitBits + 1));

  localparam int FrontLat = 3;
  localparam int RatioLat = 3 + KW;

  localparam logic [DiamW-1:0]  DiamReset  = 16'd7680;
  localparam logic [SpeedW-1:0] SpeedReset = 14'd2560;

  typedef enum logic [0:0] {
    CfgDiameter = 1'b0,
    CfgSpeed    = 1'b1
  } cpc_cfg_e;

  typedef struct packed {
    logic signed [PosW-1:0] a_pos_x;
    logic signed [PosW-1:0] a_pos_y;
    logic signed [VelW-1:0] a_vel_x;
    logic signed [VelW-1:0] a_vel_y;
    logic signed [PosW-1:0] b_pos_x;
    logic signed [PosW-1:0] b_pos_y;
    logic signed [VelW-1:0] b_vel_x;
    logic signed [VelW-1:0] b_vel_y;
  } cpc_pair_t;

  typedef struct packed {
    cpc_pair_t              pair;
    logic signed [PosW-1:0] mid_x;
    logic signed [PosW-1:0] mid_y;
    logic                   dx_neg;
    logic                   dy_neg;
    logic                   va_zero;
    logic                   vb_zero;
    logic                   skip;
  } cpc_side_t;

  typedef struct packed {
    cpc_side_t         side;
    logic [SqW-1:0]    s;
    logic [VsqW-1:0]   sva;
    logic [VsqW-1:0]   svb;
    logic [RatAW-1:0]  dx_mag;
    logic [RatAW-1:0]  dy_mag;
  } cpc_front_t;

  typedef struct packed {
    logic signed [OffW-1:0] off_x;
    logic signed [OffW-1:0] off_y;
    logic [KW-1:0]          g_x;
    logic [KW-1:0]          g_y;
    logic                   wa_zero;
    logic                   wb_zero;
    logic [3:0]             w_neg;
  } cpc_mid_t;

  typedef struct packed {
    cpc_pair_t pair;
    logic      skipped;
    logic      degenerate;
  } cpc_out_t;

  function automatic logic [VelW-1:0] vel_mag(input logic signed [VelW-1:0] v);
    logic signed [VelW-1:0] n;
    n = -v;
    return v[VelW-1] ? n : v;
  endfunction

  // (k + 1) / 2, turns the doubled floor ratio into a half-away rounding
  function automatic logic [KW-1:0] round_half(input logic [KW-1:0] k);
    logic [KW:0] t;
    t = {1'b0, k} + (KW+1)'(1);
    return t[KW:1];
  endfunction

  function automatic logic signed [OffW-1:0] apply_sign(input logic neg,
                                                       input logic [KW-1:0] mag);
    logic signed [OffW-1:0] v;
    v = signed'({1'b0, mag});
    return neg ? -v : v;
  endfunction

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [PosW:0] v);
    logic signed [PosW:0] hi;
    logic signed [PosW:0] lo;
    hi = signed'((PosW+1)'((64'd1 << (PosW - 1)) - 64'd1));
    lo = -hi - (PosW+1)'(1);
    if (v > hi) begin
      return hi[PosW-1:0];
    end else if (v < lo) begin
      return lo[PosW-1:0];
    end
    return v[PosW-1:0];
  endfunction

endpackage

// ===== hw/rtl/circle_pair_collision_resolve_top.sv =====
// top level of the circle pair collision resolver pipeline
// Resolves one colliding pair of equal circles per transfer. Pairs whose
// squared center distance is below 0.01 pass through unchanged with skipped
// set. Otherwise both centers are pushed apart to one diameter about their
// midpoint, and each velocity becomes the unit bisector of its own direction
// and its outward normal, scaled to circle_speed; where a bisector is zero the
// outward normal is used and degenerate is set. One pair enters every cycle
// while the output is not stalled; a pair passes three front stages, a round
// of 21-stage ratio units (three squaring stages and 18 bit stages each), two
// combine stages, a second such round and the output register. A stalled
// output freezes the whole pipeline. Configuration writes take effect at once
// and are meant for idle periods.
module circle_pair_collision_resolve_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_addr_i,
  input  logic [cpc_pkg::CfgW-1:0]      cfg_wdata_i,
  // input pairs
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y, zero pad
  input  logic [cpc_pkg::DataW-1:0]     s_axis_tdata,
  // resolved pairs
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // a_new_x, a_new_y, a_new_vx, a_new_vy, b_new_x, b_new_y, b_new_vx, b_new_vy, zero pad
  output logic [cpc_pkg::DataW-1:0]     m_axis_tdata,
  // skipped, degenerate
  output logic [1:0]                    m_axis_tuser
);
  import cpc_pkg::*;

  localparam int NStage  = FrontLat + RatioLat + 2 + RatioLat + 1;
  localparam int SideLen = NStage - FrontLat - 1;
  localparam int ImLen   = RatioLat + 1;
  localparam int G1N     = 10;
  localparam int G2N     = 4;

  // first round of ratio units
  localparam int IdxOx  = 0;
  localparam int IdxOy  = 1;
  localparam int IdxNx  = 2;
  localparam int IdxNy  = 3;
  localparam int IdxGx  = 4;
  localparam int IdxGy  = 5;
  localparam int IdxUax = 6;
  localparam int IdxUay = 7;
  localparam int IdxUbx = 8;
  localparam int IdxUby = 9;
  // second round, also the order of the bisector components
  localparam int IdxAx  = 0;
  localparam int IdxAy  = 1;
  localparam int IdxBx  = 2;
  localparam int IdxBy  = 3;

  logic [DiamW-1:0]  diam_q;
  logic [SpeedW-1:0] speed_q;
  logic [RatMW-1:0]  speed2;

  logic              pipe_en;
  logic [NStage-1:0] valid_q;

  cpc_pair_t  pair_in;
  cpc_front_t fo;
  cpc_side_t  sb_q [0:SideLen-1];
  cpc_side_t  side_c1, side_fin;
  cpc_mid_t   im_q [0:ImLen-1];
  cpc_mid_t   im_d, im_fin;
  cpc_out_t   out_q, out_d;

  logic [RatMW-1:0] g1_m [0:G1N-1];
  logic [RatAW-1:0] g1_a [0:G1N-1];
  logic [SqW-1:0]   g1_s [0:G1N-1];
  logic [KW-1:0]    g1_k [0:G1N-1];
  logic [RatAW-1:0] g2_a [0:G2N-1];
  logic [SqW-1:0]   g2_s [0:G2N-1];
  logic [KW-1:0]    g2_k [0:G2N-1];

  // combine stage registers
  logic signed [OffW-1:0] off_x_q, off_y_q;
  logic [KW-1:0]          g_x_q, g_y_q;
  logic signed [WW-1:0]   w_q [0:G2N-1];
  logic signed [WW-1:0]   w_d [0:G2N-1];
  logic [WMagW-1:0]       wmag_q [0:G2N-1];
  logic [WMagW-1:0]       wmag_d [0:G2N-1];
  logic [SwW-1:0]         swa_q, swb_q;

  logic signed [OffW-1:0] uax, uay, ubx, uby, nx, ny;
  logic signed [OffW-1:0] wax_s, way_s, wbx_s, wby_s;

  // --- configuration registers ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diam_q  <= DiamReset;
      speed_q <= SpeedReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgDiameter: diam_q  <= cfg_wdata_i[DiamW-1:0];
        CfgSpeed:    speed_q <= cfg_wdata_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  assign speed2 = {1'b0, speed_q, 1'b0};

  // --- handshake: the whole pipe moves unless a finished pair is held ---
  assign pipe_en       = !valid_q[NStage-1] || m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign m_axis_tvalid = valid_q[NStage-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (pipe_en) begin
      valid_q <= {valid_q[NStage-2:0], s_axis_tvalid};
    end
  end

  // --- input unpacking, first field in the low bits ---
  assign pair_in.a_pos_x = s_axis_tdata[19:0];
  assign pair_in.a_pos_y = s_axis_tdata[39:20];
  assign pair_in.a_vel_x = s_axis_tdata[54:40];
  assign pair_in.a_vel_y = s_axis_tdata[69:55];
  assign pair_in.b_pos_x = s_axis_tdata[89:70];
  assign pair_in.b_pos_y = s_axis_tdata[109:90];
  assign pair_in.b_vel_x = s_axis_tdata[124:110];
  assign pair_in.b_vel_y = s_axis_tdata[139:125];

  cpc_front u_front (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .pair_i  (pair_in),
    .front_o (fo)
  );

  // --- sideband delay line, entry i is stage FrontLat + 1 + i ---
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sb_q[0] <= fo.side;
      for (int i = 1; i < SideLen; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  assign side_c1  = sb_q[RatioLat-1];
  assign side_fin = sb_q[SideLen-1];

  // --- first round: offsets, unit normal, fallback velocity, unit velocities ---
  always_comb begin
    g1_m[IdxOx]  = diam_q;
    g1_a[IdxOx]  = fo.dx_mag;
    g1_s[IdxOx]  = fo.s;
    g1_m[IdxOy]  = diam_q;
    g1_a[IdxOy]  = fo.dy_mag;
    g1_s[IdxOy]  = fo.s;
    g1_m[IdxNx]  = UnitM;
    g1_a[IdxNx]  = fo.dx_mag;
    g1_s[IdxNx]  = fo.s;
    g1_m[IdxNy]  = UnitM;
    g1_a[IdxNy]  = fo.dy_mag;
    g1_s[IdxNy]  = fo.s;
    g1_m[IdxGx]  = speed2;
    g1_a[IdxGx]  = fo.dx_mag;
    g1_s[IdxGx]  = fo.s;
    g1_m[IdxGy]  = speed2;
    g1_a[IdxGy]  = fo.dy_mag;
    g1_s[IdxGy]  = fo.s;
    g1_m[IdxUax] = UnitM;
    g1_a[IdxUax] = RatAW'(vel_mag(fo.side.pair.a_vel_x));
    g1_s[IdxUax] = SqW'(fo.sva);
    g1_m[IdxUay] = UnitM;
    g1_a[IdxUay] = RatAW'(vel_mag(fo.side.pair.a_vel_y));
    g1_s[IdxUay] = SqW'(fo.sva);
    g1_m[IdxUbx] = UnitM;
    g1_a[IdxUbx] = RatAW'(vel_mag(fo.side.pair.b_vel_x));
    g1_s[IdxUbx] = SqW'(fo.svb);
    g1_m[IdxUby] = UnitM;
    g1_a[IdxUby] = RatAW'(vel_mag(fo.side.pair.b_vel_y));
    g1_s[IdxUby] = SqW'(fo.svb);
  end

  for (genvar i = 0; i < G1N; i++) begin : g_round1
    cpc_ratio u_ratio (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .m_i   (g1_m[i]),
      .a_i   (g1_a[i]),
      .s_i   (g1_s[i]),
      .k_o   (g1_k[i])
    );
  end

  // --- combine stage 1: signed unit vectors and bisectors ---
  // a zero velocity has a zero unit vector; the second circle's normal is
  // the first one's negated
  always_comb begin
    uax   = side_c1.va_zero ? '0
          : apply_sign(side_c1.pair.a_vel_x[VelW-1], round_half(g1_k[IdxUax]));
    uay   = side_c1.va_zero ? '0
          : apply_sign(side_c1.pair.a_vel_y[VelW-1], round_half(g1_k[IdxUay]));
    ubx   = side_c1.vb_zero ? '0
          : apply_sign(side_c1.pair.b_vel_x[VelW-1], round_half(g1_k[IdxUbx]));
    uby   = side_c1.vb_zero ? '0
          : apply_sign(side_c1.pair.b_vel_y[VelW-1], round_half(g1_k[IdxUby]));
    nx    = apply_sign(side_c1.dx_neg, round_half(g1_k[IdxNx]));
    ny    = apply_sign(side_c1.dy_neg, round_half(g1_k[IdxNy]));
    wax_s = uax + nx;
    way_s = uay + ny;
    wbx_s = ubx - nx;
    wby_s = uby - ny;
    w_d[IdxAx] = wax_s[WW-1:0];
    w_d[IdxAy] = way_s[WW-1:0];
    w_d[IdxBx] = wbx_s[WW-1:0];
    w_d[IdxBy] = wby_s[WW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      off_x_q <= apply_sign(side_c1.dx_neg, round_half(g1_k[IdxOx]));
      off_y_q <= apply_sign(side_c1.dy_neg, round_half(g1_k[IdxOy]));
      g_x_q   <= round_half(g1_k[IdxGx]);
      g_y_q   <= round_half(g1_k[IdxGy]);
      for (int i = 0; i < G2N; i++) begin
        w_q[i] <= w_d[i];
      end
    end
  end

  // --- combine stage 2: bisector lengths ---
  always_comb begin
    for (int i = 0; i < G2N; i++) begin
      wmag_d[i] = w_q[i][WW-1] ? WMagW'(-w_q[i]) : WMagW'(w_q[i]);
    end
    im_d.off_x   = off_x_q;
    im_d.off_y   = off_y_q;
    im_d.g_x     = g_x_q;
    im_d.g_y     = g_y_q;
    im_d.wa_zero = (w_q[IdxAx] == '0) && (w_q[IdxAy] == '0);
    im_d.wb_zero = (w_q[IdxBx] == '0) && (w_q[IdxBy] == '0);
    for (int i = 0; i < G2N; i++) begin
      im_d.w_neg[i] = w_q[i][WW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < G2N; i++) begin
        wmag_q[i] <= wmag_d[i];
      end
      swa_q <= SwW'(wmag_d[IdxAx]) * SwW'(wmag_d[IdxAx])
             + SwW'(wmag_d[IdxAy]) * SwW'(wmag_d[IdxAy]);
      swb_q <= SwW'(wmag_d[IdxBx]) * SwW'(wmag_d[IdxBx])
             + SwW'(wmag_d[IdxBy]) * SwW'(wmag_d[IdxBy]);
      im_q[0] <= im_d;
      for (int i = 1; i < ImLen; i++) begin
        im_q[i] <= im_q[i-1];
      end
    end
  end

  assign im_fin = im_q[ImLen-1];

  // --- second round: bisectors scaled to the speed ---
  always_comb begin
    for (int i = 0; i < G2N; i++) begin
      g2_a[i] = RatAW'(wmag_q[i]);
    end
    g2_s[IdxAx] = SqW'(swa_q);
    g2_s[IdxAy] = SqW'(swa_q);
    g2_s[IdxBx] = SqW'(swb_q);
    g2_s[IdxBy] = SqW'(swb_q);
  end

  for (genvar i = 0; i < G2N; i++) begin : g_round2
    cpc_ratio u_ratio (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .m_i   (speed2),
      .a_i   (g2_a[i]),
      .s_i   (g2_s[i]),
      .k_o   (g2_k[i])
    );
  end

  // --- output stage ---
  always_comb begin
    logic signed [OffW-1:0] vax, vay, vbx, vby;
    if (im_fin.wa_zero) begin
      vax = apply_sign(side_fin.dx_neg, im_fin.g_x);
      vay = apply_sign(side_fin.dy_neg, im_fin.g_y);
    end else begin
      vax = apply_sign(im_fin.w_neg[IdxAx], round_half(g2_k[IdxAx]));
      vay = apply_sign(im_fin.w_neg[IdxAy], round_half(g2_k[IdxAy]));
    end
    // fallback for the second circle points along minus the difference
    if (im_fin.wb_zero) begin
      vbx = apply_sign(!side_fin.dx_neg, im_fin.g_x);
      vby = apply_sign(!side_fin.dy_neg, im_fin.g_y);
    end else begin
      vbx = apply_sign(im_fin.w_neg[IdxBx], round_half(g2_k[IdxBx]));
      vby = apply_sign(im_fin.w_neg[IdxBy], round_half(g2_k[IdxBy]));
    end
    if (side_fin.skip) begin
      out_d.pair       = side_fin.pair;
      out_d.skipped    = 1'b1;
      out_d.degenerate = 1'b0;
    end else begin
      out_d.pair.a_pos_x = sat_pos((PosW+1)'(side_fin.mid_x) + (PosW+1)'(im_fin.off_x));
      out_d.pair.a_pos_y = sat_pos((PosW+1)'(side_fin.mid_y) + (PosW+1)'(im_fin.off_y));
      out_d.pair.b_pos_x = sat_pos((PosW+1)'(side_fin.mid_x) - (PosW+1)'(im_fin.off_x));
      out_d.pair.b_pos_y = sat_pos((PosW+1)'(side_fin.mid_y) - (PosW+1)'(im_fin.off_y));
      out_d.pair.a_vel_x = vax[VelW-1:0];
      out_d.pair.a_vel_y = vay[VelW-1:0];
      out_d.pair.b_vel_x = vbx[VelW-1:0];
      out_d.pair.b_vel_y = vby[VelW-1:0];
      out_d.skipped      = 1'b0;
      out_d.degenerate   = im_fin.wa_zero || im_fin.wb_zero;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = {4'b0, out_q.pair.b_vel_y, out_q.pair.b_vel_x,
                         out_q.pair.b_pos_y, out_q.pair.b_pos_x,
                         out_q.pair.a_vel_y, out_q.pair.a_vel_x,
                         out_q.pair.a_pos_y, out_q.pair.a_pos_x};
  assign m_axis_tuser = {out_q.degenerate, out_q.skipped};

  // --- assertions ---
  // a skipped pair never reports a degenerate bisector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_q.skipped && out_q.degenerate))
    else $error("skipped and degenerate both set");

  // resolved a_vel_x and b_vel_y never exceed the configured speed in magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_q.skipped) |->
      ($signed(out_q.pair.a_vel_x) <= $signed({2'b0, speed_q}) &&
       $signed(out_q.pair.a_vel_x) >= -$signed({2'b0, speed_q}) &&
       $signed(out_q.pair.b_vel_y) <= $signed({2'b0, speed_q}) &&
       $signed(out_q.pair.b_vel_y) >= -$signed({2'b0, speed_q})))
    else $error("velocity above configured speed");

  // a frozen pipe keeps every valid bit in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(valid_q))
    else $error("valid bits moved during stall");

endmodule

// ===== hw/rtl/cpc_ratio.sv =====
// pipelined bit-serial unit: largest k with k^2 * s <= (m * a)^2
module cpc_ratio (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [cpc_pkg::RatMW-1:0]   m_i,
  input  logic [cpc_pkg::RatAW-1:0]   a_i,
  input  logic [cpc_pkg::SqW-1:0]     s_i,
  output logic [cpc_pkg::KW-1:0]      k_o
);
  import cpc_pkg::*;

  localparam int PW    = RatMW + RatAW;
  localparam int PLW   = 19;
  localparam int PHW   = PW - PLW;
  localparam int RW    = 2 * PW;
  localparam int KSW   = KW + SqW;
  localparam int TW    = 80;
  localparam int Steps = KW;

  logic [PW-1:0]        p_q;
  logic [SqW-1:0]       s1_q, s2_q;
  logic [2*PHW-1:0]     hh_q;
  logic [PHW+PLW-1:0]   hl_q;
  logic [2*PLW-1:0]     ll_q;

  logic [RW-1:0]  t_q  [0:Steps-1];
  logic [KSW-1:0] ks_q [0:Steps-1];
  logic [SqW-1:0] s_q  [0:Steps-1];
  logic [KW-1:0]  k_q  [0:Steps];

  // product, split square, assembled square
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= PW'(m_i) * PW'(a_i);
      s1_q  <= s_i;
      hh_q  <= (2*PHW)'(p_q[PW-1:PLW]) * (2*PHW)'(p_q[PW-1:PLW]);
      hl_q  <= (PHW+PLW)'(p_q[PW-1:PLW]) * (PHW+PLW)'(p_q[PLW-1:0]);
      ll_q  <= (2*PLW)'(p_q[PLW-1:0]) * (2*PLW)'(p_q[PLW-1:0]);
      s2_q  <= s1_q;
      t_q[0]  <= {hh_q, {(2*PLW){1'b0}}} + RW'({hl_q, {(PLW+1){1'b0}}}) + RW'(ll_q);
      ks_q[0] <= '0;
      s_q[0]  <= s2_q;
      k_q[0]  <= '0;
    end
  end

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int B = Steps - 1 - j;
    logic [TW-1:0] term;
    logic          take;

    // (c^2 - k^2) * s with c = k + 2^b
    assign term = ({{(TW-KSW){1'b0}}, ks_q[j]} << (B + 1))
                + ({{(TW-SqW){1'b0}}, s_q[j]} << (2 * B));
    assign take = term <= {{(TW-RW){1'b0}}, t_q[j]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        k_q[j+1] <= take ? (k_q[j] | (KW'(1) << B)) : k_q[j];
      end
    end

    if (j < Steps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          t_q[j+1]  <= take ? (t_q[j] - term[RW-1:0]) : t_q[j];
          ks_q[j+1] <= take ? (ks_q[j] + ({{(KSW-SqW){1'b0}}, s_q[j]} << B)) : ks_q[j];
          s_q[j+1]  <= s_q[j];
        end
      end
    end
  end

  assign k_o = k_q[Steps];

endmodule

// ===== hw/rtl/cpc_front.sv =====
// front stages: differences, midpoint, squared lengths and coincidence test
module cpc_front (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  cpc_pkg::cpc_pair_t   pair_i,
  output cpc_pkg::cpc_front_t  front_o
);
  import cpc_pkg::*;

  localparam int Vsq1W = VsqW - 1;

  cpc_pair_t               pair1_q, pair2_q;
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic signed [PosW-1:0]  mx1_q, my1_q, mx2_q, my2_q;
  logic                    dxn_q, dyn_q;
  logic [RatAW-1:0]        dxm_q, dym_q;
  logic [SqW-1:0]          dx2_q, dy2_q;
  logic [Vsq1W-1:0]        vax2_q, vay2_q, vbx2_q, vby2_q;
  logic signed [DiffW-1:0] sum_x, sum_y, dxa, dya;
  logic [SqW-1:0]          s_sum;
  logic [VelW-1:0]         m_ax, m_ay, m_bx, m_by;

  assign sum_x = DiffW'(pair_i.a_pos_x) + DiffW'(pair_i.b_pos_x);
  assign sum_y = DiffW'(pair_i.a_pos_y) + DiffW'(pair_i.b_pos_y);
  assign dxa   = dx_q[DiffW-1] ? -dx_q : dx_q;
  assign dya   = dy_q[DiffW-1] ? -dy_q : dy_q;
  assign m_ax  = vel_mag(pair1_q.a_vel_x);
  assign m_ay  = vel_mag(pair1_q.a_vel_y);
  assign m_bx  = vel_mag(pair1_q.b_vel_x);
  assign m_by  = vel_mag(pair1_q.b_vel_y);
  assign s_sum = dx2_q + dy2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pair1_q <= pair_i;
      dx_q    <= DiffW'(pair_i.a_pos_x) - DiffW'(pair_i.b_pos_x);
      dy_q    <= DiffW'(pair_i.a_pos_y) - DiffW'(pair_i.b_pos_y);
      mx1_q   <= sum_x[DiffW-1:1];
      my1_q   <= sum_y[DiffW-1:1];

      pair2_q <= pair1_q;
      mx2_q   <= mx1_q;
      my2_q   <= my1_q;
      dxn_q   <= dx_q[DiffW-1];
      dyn_q   <= dy_q[DiffW-1];
      dxm_q   <= dxa;
      dym_q   <= dya;
      dx2_q   <= SqW'(dxa) * SqW'(dxa);
      dy2_q   <= SqW'(dya) * SqW'(dya);
      vax2_q  <= Vsq1W'(m_ax) * Vsq1W'(m_ax);
      vay2_q  <= Vsq1W'(m_ay) * Vsq1W'(m_ay);
      vbx2_q  <= Vsq1W'(m_bx) * Vsq1W'(m_bx);
      vby2_q  <= Vsq1W'(m_by) * Vsq1W'(m_by);

      front_o.side.pair    <= pair2_q;
      front_o.side.mid_x   <= mx2_q;
      front_o.side.mid_y   <= my2_q;
      front_o.side.dx_neg  <= dxn_q;
      front_o.side.dy_neg  <= dyn_q;
      front_o.side.va_zero <= (vax2_q == '0) && (vay2_q == '0);
      front_o.side.vb_zero <= (vbx2_q == '0) && (vby2_q == '0);
      front_o.side.skip    <= s_sum <= SkipMax;
      front_o.s            <= s_sum;
      front_o.sva          <= VsqW'(vax2_q) + VsqW'(vay2_q);
      front_o.svb          <= VsqW'(vbx2_q) + VsqW'(vby2_q);
      front_o.dx_mag       <= dxm_q;
      front_o.dy_mag       <= dym_q;
    end
  end

endmodule
